// ----- hdl/srf_pkg.sv -----
// Shared types, constants and the control store of the secant root finder.
package srf_pkg;

  localparam int CFG_AW    = 3;
  localparam int TOL_W     = 31;
  localparam int ITER_W    = 7;
  localparam int PC_W      = 5;
  localparam int UCODE_LEN = 2 ** PC_W;
  localparam int NUM_W     = 64;
  localparam int DEN_W     = 33;
  localparam int QUO_W     = 42;
  localparam int DIV_STEPS = NUM_W;
  localparam int STEP_W    = $clog2(DIV_STEPS + 1);

  localparam logic [TOL_W-1:0] TOL_RESET = 31'd1966;
  localparam logic             REG_TOL   = 1'b0;
  localparam logic [NUM_W-1:0] Q_LIMIT   = 64'h0000_0100_0000_0000;

  typedef enum logic [1:0] {
    ST_CONV  = 2'd0,
    ST_LIMIT = 2'd1,
    ST_ZERO  = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [31:0] first_guess;
    logic signed [31:0] second_guess;
  } in_t;

  typedef struct packed {
    logic signed [31:0] root;
    logic signed [31:0] residual;
    logic [ITER_W-1:0]  iterations;
    status_t            status;
  } out_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_SQ,
    OP_CUBE,
    OP_SUM,
    OP_DIFF,
    OP_MUL,
    OP_DIV,
    OP_UPDATE,
    OP_SHIFT,
    OP_TAKE,
    OP_FINISH
  } op_t;

  typedef enum logic [1:0] {
    SEL_0,
    SEL_1,
    SEL_2
  } sel_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_IDLE,
    C_DEN_ZERO,
    C_DIV_BUSY,
    C_CONV,
    C_LIMIT
  } cond_t;

  typedef struct packed {
    op_t             op;
    sel_t            sel;
    logic            cnt_inc;
    status_t         stat;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic den_zero;
    logic div_busy;
    logic converged;
    logic at_limit;
  } flags_t;

  localparam logic [PC_W-1:0] L_IDLE  = 5'd0;
  localparam logic [PC_W-1:0] L_WAIT0 = 5'd10;
  localparam logic [PC_W-1:0] L_TEST  = 5'd15;
  localparam logic [PC_W-1:0] L_WAIT1 = 5'd21;
  localparam logic [PC_W-1:0] L_CONV  = 5'd27;
  localparam logic [PC_W-1:0] L_LIMIT = 5'd28;
  localparam logic [PC_W-1:0] L_ZERO  = 5'd29;

  function automatic uword_t uw(op_t op, sel_t sel, logic inc, status_t st, cond_t cond,
                                logic [PC_W-1:0] tgt);
    uword_t w;
    w.op      = op;
    w.sel     = sel;
    w.cnt_inc = inc;
    w.stat    = st;
    w.cond    = cond;
    w.target  = tgt;
    return w;
  endfunction

  // The select field names the point for the polynomial steps; a sum step
  // writes the f register of the same index.
  localparam uword_t UCODE [UCODE_LEN] = '{
    uw(OP_NOP,    SEL_0, 1'b0, ST_CONV,  C_IDLE,     L_IDLE),   // 0: wait for start
    uw(OP_SQ,     SEL_0, 1'b0, ST_CONV,  C_NEVER,    L_IDLE),   // 1: f0 = f(x0)
    uw(OP_CUBE,   SEL_0, 1'b0, ST_CONV,  C_NEVER,    L_IDLE),
    uw(OP_SUM,    SEL_0, 1'b0, ST_CONV,  C_NEVER,    L_IDLE),
    uw(OP_SQ,     SEL_1, 1'b0, ST_CONV,  C_NEVER,    L_IDLE),   // 4: f1 = f(x1)
    uw(OP_CUBE,   SEL_1, 1'b0, ST_CONV,  C_NEVER,    L_IDLE),
    uw(OP_SUM,    SEL_1, 1'b0, ST_CONV,  C_NEVER,    L_IDLE),
    uw(OP_DIFF,   SEL_0, 1'b0, ST_CONV,  C_DEN_ZERO, L_ZERO),   // 7: first estimate
    uw(OP_MUL,    SEL_0, 1'b0, ST_CONV,  C_NEVER,    L_IDLE),
    uw(OP_DIV,    SEL_0, 1'b0, ST_CONV,  C_NEVER,    L_IDLE),
    uw(OP_NOP,    SEL_0, 1'b0, ST_CONV,  C_DIV_BUSY, L_WAIT0),
    uw(OP_UPDATE, SEL_0, 1'b0, ST_CONV,  C_NEVER,    L_IDLE),
    uw(OP_SQ,     SEL_2, 1'b0, ST_CONV,  C_NEVER,    L_IDLE),   // 12: f2 = f(x2)
    uw(OP_CUBE,   SEL_2, 1'b0, ST_CONV,  C_NEVER,    L_IDLE),
    uw(OP_SUM,    SEL_2, 1'b0, ST_CONV,  C_NEVER,    L_IDLE),
    uw(OP_NOP,    SEL_0, 1'b0, ST_CONV,  C_CONV,     L_CONV),   // 15: loop test
    uw(OP_NOP,    SEL_0, 1'b0, ST_CONV,  C_LIMIT,    L_LIMIT),
    uw(OP_SHIFT,  SEL_0, 1'b0, ST_CONV,  C_NEVER,    L_IDLE),
    uw(OP_DIFF,   SEL_0, 1'b0, ST_CONV,  C_DEN_ZERO, L_ZERO),
    uw(OP_MUL,    SEL_0, 1'b0, ST_CONV,  C_NEVER,    L_IDLE),
    uw(OP_DIV,    SEL_0, 1'b0, ST_CONV,  C_NEVER,    L_IDLE),
    uw(OP_NOP,    SEL_0, 1'b0, ST_CONV,  C_DIV_BUSY, L_WAIT1),
    uw(OP_UPDATE, SEL_0, 1'b1, ST_CONV,  C_NEVER,    L_IDLE),
    uw(OP_SQ,     SEL_2, 1'b0, ST_CONV,  C_NEVER,    L_IDLE),
    uw(OP_CUBE,   SEL_2, 1'b0, ST_CONV,  C_NEVER,    L_IDLE),
    uw(OP_SUM,    SEL_2, 1'b0, ST_CONV,  C_NEVER,    L_IDLE),
    uw(OP_NOP,    SEL_0, 1'b0, ST_CONV,  C_ALWAYS,   L_TEST),
    uw(OP_FINISH, SEL_0, 1'b0, ST_CONV,  C_ALWAYS,   L_IDLE),   // 27: converged
    uw(OP_FINISH, SEL_0, 1'b0, ST_LIMIT, C_ALWAYS,   L_IDLE),   // 28: limit
    uw(OP_TAKE,   SEL_0, 1'b0, ST_CONV,  C_NEVER,    L_IDLE),   // 29: zero denominator
    uw(OP_FINISH, SEL_0, 1'b0, ST_ZERO,  C_ALWAYS,   L_IDLE),
    uw(OP_NOP,    SEL_0, 1'b0, ST_CONV,  C_ALWAYS,   L_IDLE)
  };

endpackage

// ----- hdl/secant_root_finder_top.sv -----
// Top level of the secant root finder for f(x) = x^3 + 8x - 7.
//
//  channel  | ports                                  | transfer when
//  ---------+----------------------------------------+-------------------------------
//  input    | start, busy, in_data                   | start high and busy low
//  result   | out_valid, out_data                    | out_valid high (one cycle)
//  config   | psel, penable, pwrite, paddr, pwdata,  | psel, penable, pwrite, pready
//           | prdata, pready                         |
//
// One item at a time. Each secant update beyond the first estimate lengthens the run,
// and a zero denominator on the first step gives the result without any divide.
// Most of the run is spent in the 64-step serial divider, which holds the sequencer
// while it works on each update. The result strobe comes in the cycle after the last
// control step, and busy is low in that same cycle.
// Reset (rst_n low, synchronous) returns the sequencer to idle and sets the
// tolerance to 1966. Results cannot be stalled.
module secant_root_finder_top import srf_pkg::*; #(
  parameter int MAX_ITER = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              start,
  output logic              busy,
  input  in_t               in_data,
  output logic              out_valid,
  output out_t              out_data
);

  logic [TOL_W-1:0] tol_r;
  logic             cfg_wr;
  logic             accept;
  uword_t           uword;
  flags_t           flags;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[CFG_AW-1:2] == REG_TOL);
  assign prdata = (paddr[CFG_AW-1:2] == REG_TOL) ? {1'b0, tol_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_wr) begin
      tol_r <= pwdata[TOL_W-1:0];
    end
  end

  assign accept = start && !busy;

  srf_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .flags (flags),
    .uword (uword),
    .busy  (busy)
  );

  srf_dp #(
    .MAX_ITER (MAX_ITER)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .in_data   (in_data),
    .uword     (uword),
    .tol       (tol_r),
    .flags     (flags),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ----- hdl/srf_seq.sv -----
// Microcode sequencer: step counter, control store lookup and jump logic.
module srf_seq import srf_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   start,
  input  flags_t flags,
  output uword_t uword,
  output logic   busy
);

  logic [PC_W-1:0] pc_r;
  logic [PC_W-1:0] pc_nxt;
  logic            jump;

  assign uword = UCODE[pc_r];
  assign busy  = (pc_r != L_IDLE);

  always_comb begin
    unique case (uword.cond)
      C_NEVER:    jump = 1'b0;
      C_ALWAYS:   jump = 1'b1;
      C_IDLE:     jump = !start;
      C_DEN_ZERO: jump = flags.den_zero;
      C_DIV_BUSY: jump = flags.div_busy;
      C_CONV:     jump = flags.converged;
      C_LIMIT:    jump = flags.at_limit;
      default:    jump = 1'b1;
    endcase
    pc_nxt = jump ? uword.target : pc_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= L_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// ----- hdl/srf_div.sv -----
// Restoring divider, one quotient bit per cycle, with the quotient clamp.
module srf_div import srf_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] num,
  input  logic signed [DEN_W-1:0] den,
  output logic                    busy,
  output logic signed [QUO_W-1:0] quot
);

  logic              busy_r;
  logic [STEP_W-1:0] step_r;
  logic [DEN_W-1:0]  rem_r;
  logic [NUM_W-1:0]  nq_r;
  logic [DEN_W-1:0]  dmag_r;
  logic              neg_r;
  logic signed [QUO_W-1:0] quot_r;

  logic [DEN_W+1:0]  trial;
  logic              ge;
  logic              last;
  logic [NUM_W-1:0]  num_mag;
  logic [DEN_W-1:0]  den_mag;
  logic [QUO_W-2:0]  qclamp;

  assign num_mag = num[NUM_W-1] ? NUM_W'(-num) : num;
  assign den_mag = den[DEN_W-1] ? DEN_W'(-den) : den;
  // The partial remainder with the next dividend bit, minus the divisor.
  assign trial   = {1'b0, rem_r, nq_r[NUM_W-1]} - {2'b00, dmag_r};
  assign ge      = !trial[DEN_W+1];
  assign last    = (step_r == STEP_W'(DIV_STEPS));
  assign qclamp  = (nq_r > Q_LIMIT) ? Q_LIMIT[QUO_W-2:0] : nq_r[QUO_W-2:0];

  assign busy = busy_r;
  assign quot = quot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && last) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      step_r <= '0;
      rem_r  <= '0;
      nq_r   <= num_mag;
      dmag_r <= den_mag;
      neg_r  <= num[NUM_W-1] ^ den[DEN_W-1];
    end else if (busy_r && !last) begin
      step_r <= step_r + 1'b1;
      rem_r  <= ge ? trial[DEN_W-1:0] : {rem_r[DEN_W-2:0], nq_r[NUM_W-1]};
      nq_r   <= {nq_r[NUM_W-2:0], ge};
    end else if (busy_r) begin
      quot_r <= neg_r ? -$signed({1'b0, qclamp}) : $signed({1'b0, qclamp});
    end
  end

endmodule

// ----- hdl/srf_dp.sv -----
// Datapath: point and f registers, polynomial unit, secant step and result register.
module srf_dp import srf_pkg::*; #(
  parameter int MAX_ITER = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  in_t              in_data,
  input  uword_t           uword,
  input  logic [TOL_W-1:0] tol,
  output flags_t           flags,
  output logic             out_valid,
  output out_t             out_data
);

  localparam int CNT_W = $clog2(MAX_ITER + 1);

  localparam logic signed [31:0] CUBE_LIM   = 32'sd4194304;
  localparam logic signed [31:0] CUBE_LIM_N = -32'sd4194304;
  localparam logic signed [31:0] F_MAX      = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] F_MIN      = 32'sh8000_0000;
  localparam logic signed [37:0] SEVEN_Q    = 38'sd458752;
  localparam logic signed [47:0] S_MAX      = 48'sh0000_7FFF_FFFF;
  localparam logic signed [47:0] S_MIN      = -48'sh0000_8000_0000;

  function automatic logic signed [31:0] sat32(logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > S_MAX) begin
      r = F_MAX;
    end else if (v < S_MIN) begin
      r = F_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  logic signed [31:0] x0_r, x1_r, x2_r;
  logic signed [31:0] f0_r, f1_r, f2_r;
  logic [27:0]        sq_r;
  logic signed [51:0] cube_r;
  logic signed [32:0] dx_r;
  logic signed [DEN_W-1:0] den_r;
  logic signed [NUM_W-1:0] num_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               out_valid_r;
  out_t               out_data_r;

  logic signed [31:0] xs;
  logic signed [22:0] xn;
  logic signed [45:0] sq_full;
  logic signed [51:0] cube_full;
  logic signed [37:0] poly_sum;
  logic signed [31:0] poly_val;
  logic signed [64:0] num_full;
  logic signed [42:0] upd;
  logic [31:0]        f2_mag;
  logic               div_busy;
  logic signed [QUO_W-1:0] quot;

  always_comb begin
    unique case (uword.sel)
      SEL_0:   xs = x0_r;
      SEL_1:   xs = x1_r;
      SEL_2:   xs = x2_r;
      default: xs = x2_r;
    endcase
  end

  // Only the low 23 bits matter: larger points saturate f outright.
  assign xn        = xs[22:0];
  assign sq_full   = xn * xn;
  assign cube_full = $signed({1'b0, sq_r}) * xn;
  assign poly_sum  = {{2{cube_r[51]}}, cube_r[51:16]} + {{3{xs[31]}}, xs, 3'b000} - SEVEN_Q;

  always_comb begin
    if (xs >= CUBE_LIM) begin
      poly_val = F_MAX;
    end else if (xs <= CUBE_LIM_N) begin
      poly_val = F_MIN;
    end else begin
      poly_val = sat32({{10{poly_sum[37]}}, poly_sum});
    end
  end

  assign num_full = f1_r * dx_r;
  assign upd      = {{11{x1_r[31]}}, x1_r} - {quot[QUO_W-1], quot};
  assign f2_mag   = f2_r[31] ? 32'(-f2_r) : f2_r;

  srf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (uword.op == OP_DIV),
    .num   (num_r),
    .den   (den_r),
    .busy  (div_busy),
    .quot  (quot)
  );

  assign flags.den_zero  = (f1_r == f0_r);
  assign flags.div_busy  = div_busy;
  assign flags.converged = (f2_mag <= {1'b0, tol});
  assign flags.at_limit  = (cnt_r >= CNT_W'(MAX_ITER));

  always_ff @(posedge clk) begin
    if (load) begin
      x0_r  <= in_data.first_guess;
      x1_r  <= in_data.second_guess;
      cnt_r <= '0;
    end else begin
      unique case (uword.op)
        OP_SQ:   sq_r   <= sq_full[43:16];
        OP_CUBE: cube_r <= cube_full;
        OP_SUM: begin
          unique case (uword.sel)
            SEL_0:   f0_r <= poly_val;
            SEL_1:   f1_r <= poly_val;
            default: f2_r <= poly_val;
          endcase
        end
        OP_DIFF: begin
          dx_r  <= {x1_r[31], x1_r} - {x0_r[31], x0_r};
          den_r <= {f1_r[31], f1_r} - {f0_r[31], f0_r};
        end
        OP_MUL:  num_r <= num_full[NUM_W-1:0];
        OP_UPDATE: begin
          x2_r <= sat32({{5{upd[42]}}, upd});
          if (uword.cnt_inc) begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        OP_SHIFT: begin
          x0_r <= x1_r;
          f0_r <= f1_r;
          x1_r <= x2_r;
          f1_r <= f2_r;
        end
        OP_TAKE: begin
          x2_r <= x1_r;
          f2_r <= f1_r;
        end
        OP_FINISH: begin
          out_data_r.root       <= x2_r;
          out_data_r.residual   <= f2_r;
          out_data_r.iterations <= ITER_W'(cnt_r);
          out_data_r.status     <= uword.stat;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (uword.op == OP_FINISH);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- hdl/srf_checker.sv -----
// Port-level checks of the secant root finder, bound to the top level.
module srf_port_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  // A result transfer is a single-cycle strobe.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  // An accepted item makes the block busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after an accepted item");

  // A result only follows work in progress.
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a preceding busy cycle");

  // The block is free again when its result is shown.
  a_idle_at_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("block still busy while showing its result");

endmodule

bind secant_root_finder_top srf_port_checker u_srf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);
